// File: rtl/mbrtu_pkg.sv
// Shared types, constants and the CRC byte step for the Modbus RTU response parser.
`default_nettype none
package mbrtu_pkg;

  // Frame layout constants.
  localparam logic [7:0] FN_READ    = 8'h03;
  localparam logic [7:0] EXC_BIT    = 8'h80;
  localparam logic [7:0] FN_EXC     = 8'h83;
  localparam logic [7:0] DATA_BYTES = 8'd16;
  localparam logic [4:0] REPLY_LEN  = 5'd21;
  localparam logic [4:0] EXC_LEN    = 5'd5;
  localparam logic [4:0] DATA_FIRST = 5'd3;
  localparam logic [4:0] DATA_LAST  = 5'd18;
  localparam logic [4:0] MAX_RES_M1 = 5'd31;

  // Range limits for the telemetry checks.
  localparam logic signed [15:0] TEMP_MIN   = -16'sd40;
  localparam logic signed [15:0] TEMP_MAX   = 16'sd150;
  localparam logic signed [22:0] TEMP_SCALE = 23'sd100;
  localparam logic [15:0]        DIR_MAX    = 16'd3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_VALID      = 3'd1,
    ST_MISMATCH   = 3'd2,
    ST_BAD        = 3'd3,
    ST_CRC_ERR    = 3'd4,
    ST_EXCEPTION  = 3'd5,
    ST_OVERFLOW   = 3'd6
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_USE,
    S_CHECK,
    S_OUT
  } state_e;

  // Control from the sequencer to the CRC unit.
  typedef struct packed {
    logic init;
    logic en;
  } crc_ctrl_t;

  // One byte of Modbus CRC-16 (reflected polynomial 0xA001), eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mbrtu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/mbrtu_crc.sv
// CRC-16 accumulator that takes one byte per cycle.
`default_nettype none
module mbrtu_crc (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mbrtu_pkg::crc_ctrl_t ctrl_i,
  input  wire logic [7:0]           data_i,
  output logic      [15:0]          crc_o
);

  logic [15:0] crc_q, crc_d;

  // Restart at all ones or fold in one byte.
  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = 16'hFFFF;
    end else if (ctrl_i.en) begin
      crc_d = mbrtu_pkg::crc_byte(crc_q, data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'hFFFF;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule
`default_nettype wire

// File: rtl/modbus_rtu_telemetry_response_parser.sv
// Top level of the Modbus RTU telemetry response parser.
// Received bytes are kept in a ring buffer of BUF_DEPTH bytes; after each byte a
// sequencer rescans the buffer front, reading each byte from the buffer RAM in
// an S_RD then S_USE state pair, and emits one result per framing outcome until
// the outcome is incomplete (at most 32 results per request). A scan reads the
// header bytes for a short or incomplete check and also the full 21-byte reply
// with CRC for a reply and waits while the output is stalled. A request may
// take up to 32 scans. An accepted result that ends a request returns the block
// to accepting on the next cycle; a clear request presents its one result on the
// cycle after it is taken. The input is stalled while a request is in work.
// Results are zero in every telemetry field unless status is valid.
`default_nettype none
module modbus_rtu_telemetry_response_parser #(
  parameter int BUF_DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [7:0]         data_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              status_o,
  output logic                    last_o,
  output logic [15:0]             fault_word_o,
  output logic [15:0]             current_centiamps_o,
  output logic [15:0]             rpm_o,
  output logic signed [14:0]      temperature_centideg_o,
  output logic [15:0]             voltage_decivolts_o,
  output logic [1:0]              direction_o,
  output logic [31:0]             hall_ticks_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [AW:0]   DEP  = (AW+1)'(BUF_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(BUF_DEPTH);

  mbrtu_pkg::state_e state_q, state_d;
  logic [7:0]    addr_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [4:0]    idx_q, idx_d;
  logic [4:0]    flen_q, flen_d;
  logic          body_q, body_d;
  logic          match_q, match_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [127:0]  data_q;
  logic [7:0]    rxlo_q, rxhi_q;

  logic [2:0]    status_q;
  logic          last_q;
  logic [15:0]   fault_q, cur_q, rpm_q, volt_q;
  logic [14:0]   temp_q;
  logic [1:0]    dir_q;
  logic [31:0]   hall_q;

  logic          we;
  logic [AW:0]   wsum, rsum, hsum;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic [15:0]   crc;
  mbrtu_pkg::crc_ctrl_t crc_ctrl;

  logic          drop_en;
  logic [4:0]    drop_n;
  logic          res_en, res_last, res_telem;
  mbrtu_pkg::status_e res_status;
  logic          shift_en, rxlo_en, rxhi_en;
  logic [4:0]    flen_v;
  logic          len_ok;

  logic signed [15:0] temp_s;
  logic signed [22:0] temp_prod;
  logic [15:0]        dir_r;

  // Buffer addresses: head plus offset, wrapped once.
  assign wsum  = {1'b0, head_q} + (AW+1)'(fill_q);
  assign waddr = (wsum >= DEP) ? AW'(wsum - DEP) : AW'(wsum);
  assign rsum  = {1'b0, head_q} + (AW+1)'(idx_q);
  assign raddr = (rsum >= DEP) ? AW'(rsum - DEP) : AW'(rsum);

  mbrtu_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mbrtu_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (rdata),
    .crc_o  (crc)
  );

  // Register fields of a collected reply.
  assign temp_s    = $signed(data_q[79:64]);
  assign dir_r     = data_q[47:32];
  assign temp_prod = $signed({{7{temp_s[15]}}, temp_s}) * mbrtu_pkg::TEMP_SCALE;

  // Sequencer: next state, result emission and buffer drops.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    flen_d     = flen_q;
    body_d     = body_q;
    match_d    = match_q;
    cnt_d      = cnt_q;
    we         = 1'b0;
    drop_en    = 1'b0;
    drop_n     = 5'd1;
    res_en     = 1'b0;
    res_status = mbrtu_pkg::ST_INCOMPLETE;
    res_last   = 1'b0;
    res_telem  = 1'b0;
    shift_en   = 1'b0;
    rxlo_en    = 1'b0;
    rxhi_en    = 1'b0;
    crc_ctrl   = '0;
    flen_v     = mbrtu_pkg::EXC_LEN;
    len_ok     = 1'b0;
    fill_d     = fill_q;
    head_d     = head_q;

    case (state_q)
      mbrtu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cnt_d = 5'd0;
          if (op_i) begin
            fill_d     = '0;
            head_d     = '0;
            res_en     = 1'b1;
            res_status = mbrtu_pkg::ST_INCOMPLETE;
            res_last   = 1'b1;
          end else if (fill_q >= FULL) begin
            res_en     = 1'b1;
            res_status = mbrtu_pkg::ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            fill_d  = fill_q + 1'b1;
            state_d = mbrtu_pkg::S_SCAN;
          end
        end
      end

      mbrtu_pkg::S_SCAN: begin
        if (fill_q == '0) begin
          res_en = 1'b1;
        end else begin
          idx_d   = 5'd0;
          body_d  = 1'b0;
          state_d = mbrtu_pkg::S_RD;
        end
      end

      mbrtu_pkg::S_RD: begin
        state_d = mbrtu_pkg::S_USE;
      end

      mbrtu_pkg::S_USE: begin
        if (!body_q) begin
          // Header bytes: address, function, byte count.
          if (idx_q == 5'd0) begin
            match_d = (rdata == addr_q);
            if (fill_q < CW'(2)) begin
              res_en = 1'b1;
            end else begin
              idx_d   = 5'd1;
              state_d = mbrtu_pkg::S_RD;
            end
          end else if (idx_q == 5'd1) begin
            if (rdata == mbrtu_pkg::FN_READ) begin
              if (fill_q < CW'(3)) begin
                res_en = 1'b1;
              end else begin
                idx_d   = 5'd2;
                state_d = mbrtu_pkg::S_RD;
              end
            end else if (rdata == mbrtu_pkg::FN_EXC) begin
              flen_v = mbrtu_pkg::EXC_LEN;
              len_ok = 1'b1;
            end else begin
              drop_en    = 1'b1;
              res_en     = 1'b1;
              res_status = match_q ? mbrtu_pkg::ST_BAD : mbrtu_pkg::ST_MISMATCH;
            end
          end else begin
            if (rdata != mbrtu_pkg::DATA_BYTES) begin
              drop_en    = 1'b1;
              res_en     = 1'b1;
              res_status = match_q ? mbrtu_pkg::ST_BAD : mbrtu_pkg::ST_MISMATCH;
            end else begin
              flen_v = mbrtu_pkg::REPLY_LEN;
              len_ok = 1'b1;
            end
          end
          // Known frame kind: wait for the whole frame, skip it or check it.
          if (len_ok) begin
            flen_d = flen_v;
            if (fill_q < CW'(flen_v)) begin
              res_en = 1'b1;
            end else if (!match_q) begin
              drop_en    = 1'b1;
              drop_n     = flen_v;
              res_en     = 1'b1;
              res_status = mbrtu_pkg::ST_MISMATCH;
            end else begin
              crc_ctrl.init = 1'b1;
              body_d        = 1'b1;
              idx_d         = 5'd0;
              state_d       = mbrtu_pkg::S_RD;
            end
          end
        end else begin
          // Frame body: CRC over all but the last two bytes, collect registers.
          crc_ctrl.en = (idx_q < flen_q - 5'd2);
          shift_en    = (idx_q >= mbrtu_pkg::DATA_FIRST) && (idx_q <= mbrtu_pkg::DATA_LAST);
          rxlo_en     = (idx_q == flen_q - 5'd2);
          rxhi_en     = (idx_q == flen_q - 5'd1);
          if (rxhi_en) begin
            state_d = mbrtu_pkg::S_CHECK;
          end else begin
            idx_d   = idx_q + 5'd1;
            state_d = mbrtu_pkg::S_RD;
          end
        end
      end

      mbrtu_pkg::S_CHECK: begin
        res_en  = 1'b1;
        drop_en = 1'b1;
        if ({rxhi_q, rxlo_q} != crc) begin
          res_status = mbrtu_pkg::ST_CRC_ERR;
        end else if (flen_q == mbrtu_pkg::EXC_LEN) begin
          drop_n     = mbrtu_pkg::EXC_LEN;
          res_status = mbrtu_pkg::ST_EXCEPTION;
        end else if (temp_s < mbrtu_pkg::TEMP_MIN || temp_s > mbrtu_pkg::TEMP_MAX ||
                     dir_r > mbrtu_pkg::DIR_MAX) begin
          res_status = mbrtu_pkg::ST_BAD;
        end else begin
          drop_n     = mbrtu_pkg::REPLY_LEN;
          res_status = mbrtu_pkg::ST_VALID;
          res_telem  = 1'b1;
        end
      end

      mbrtu_pkg::S_OUT: begin
        if (!out_stall_i) begin
          cnt_d   = cnt_q + 5'd1;
          state_d = last_q ? mbrtu_pkg::S_IDLE : mbrtu_pkg::S_SCAN;
        end
      end

      default: begin
        state_d = mbrtu_pkg::S_IDLE;
      end
    endcase

    // A scan outcome ends the request when incomplete or at the result limit.
    if (res_en) begin
      state_d = mbrtu_pkg::S_OUT;
      if (res_status == mbrtu_pkg::ST_INCOMPLETE || cnt_d == mbrtu_pkg::MAX_RES_M1) begin
        res_last = 1'b1;
      end
    end

    // Drop bytes from the buffer front; dropping everything rewinds the head.
    hsum = {1'b0, head_q} + (AW+1)'(drop_n);
    if (drop_en) begin
      if (CW'(drop_n) >= fill_q) begin
        fill_d = '0;
        head_d = '0;
      end else begin
        fill_d = fill_q - CW'(drop_n);
        head_d = (hsum >= DEP) ? AW'(hsum - DEP) : AW'(hsum);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbrtu_pkg::S_IDLE;
      addr_q  <= 8'd1;
      head_q  <= '0;
      fill_q  <= '0;
      idx_q   <= 5'd0;
      flen_q  <= mbrtu_pkg::EXC_LEN;
      body_q  <= 1'b0;
      match_q <= 1'b0;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      flen_q  <= flen_d;
      body_q  <= body_d;
      match_q <= match_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        addr_q <= cfg_data_i;
      end
    end
  end

  // Frame payload registers and the result register.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      data_q <= {data_q[119:0], rdata};
    end
    if (rxlo_en) begin
      rxlo_q <= rdata;
    end
    if (rxhi_en) begin
      rxhi_q <= rdata;
    end
    if (res_en) begin
      status_q <= res_status;
      last_q   <= res_last;
      fault_q  <= res_telem ? data_q[127:112] : 16'd0;
      cur_q    <= res_telem ? data_q[111:96]  : 16'd0;
      rpm_q    <= res_telem ? data_q[95:80]   : 16'd0;
      temp_q   <= res_telem ? temp_prod[14:0] : 15'd0;
      volt_q   <= res_telem ? data_q[63:48]   : 16'd0;
      dir_q    <= res_telem ? dir_r[1:0]      : 2'd0;
      hall_q   <= res_telem ? data_q[31:0]    : 32'd0;
    end
  end

  assign cfg_ready_o            = 1'b1;
  assign in_stall_o             = (state_q != mbrtu_pkg::S_IDLE);
  assign out_valid_o            = (state_q == mbrtu_pkg::S_OUT);
  assign status_o               = status_q;
  assign last_o                 = last_q;
  assign fault_word_o           = fault_q;
  assign current_centiamps_o    = cur_q;
  assign rpm_o                  = rpm_q;
  assign temperature_centideg_o = temp_q;
  assign voltage_decivolts_o    = volt_q;
  assign direction_o            = dir_q;
  assign hall_ticks_o           = hall_q;

  // The buffer never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FULL)
    else $error("fill count exceeds buffer depth");

  // A clear request yields one final incomplete result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && op_i |=>
      out_valid_o && last_o && status_o == mbrtu_pkg::ST_INCOMPLETE)
    else $error("clear did not produce a final incomplete result");

  // Taking a final result frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !in_stall_o && !out_valid_o)
    else $error("block did not return to accepting after final result");

  // Hall ticks and fault word are zero unless the result is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mbrtu_pkg::ST_VALID |-> hall_ticks_o == 32'd0 &&
      fault_word_o == 16'd0)
    else $error("telemetry fields set on a non-valid result");

endmodule
`default_nettype wire
